>>> src/fbde_pkg.sv
// ----------------------------------------------------------------------------
// fbde_pkg
// Shared widths, range limits, fraction code tables and types for the
// fractional baud divisor encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fbde_pkg;

	// Field widths
	localparam int BAUD_W  = 24;
	localparam int WORD_W  = 16;
	localparam int INT_W   = 14;
	// Eighths bits consumed by the encoder: 14 integer bits + 3 fraction bits
	localparam int EIGHT_W = INT_W + 3;

	// Default reference clock
	localparam int unsigned REF_CLOCK_HZ_DEF = 32'd48000000;

	// Accepted baud range
	localparam logic [BAUD_W-1:0] BAUD_MIN = 24'd184;
	localparam logic [BAUD_W-1:0] BAUD_MAX = 24'd12000000;

	// Fraction codes in bits 15..14 of the divisor word
	localparam logic [1:0] FRAC_NONE    = 2'b00;
	localparam logic [1:0] FRAC_HALF    = 2'b01;
	localparam logic [1:0] FRAC_QUARTER = 2'b10;
	localparam logic [1:0] FRAC_EIGHTH  = 2'b11;

	// Special divisor words at the top rates
	localparam logic [WORD_W-1:0] WORD_ONE      = 16'h0001;
	localparam logic [WORD_W-1:0] WORD_ZERO     = 16'h0000;
	localparam logic [WORD_W-1:0] WORD_HALF_ONE = 16'h4001;

	// Chip generation selected by the mode register
	typedef enum logic {
		CHIP_NEWER = 1'b0,
		CHIP_OLDER = 1'b1
	} chip_mode_t;

	// Control that travels along the divider cells
	typedef struct packed {
		logic valid;
		logic oor;
	} cell_ctl_t;

	// Newer chip: fraction code per eighth
	function automatic logic [1:0] newer_frac_code(input logic [2:0] f);
		logic [1:0] c;
		case (f)
			3'd0: c = FRAC_NONE;
			3'd1: c = FRAC_EIGHTH;
			3'd2: c = FRAC_QUARTER;
			3'd3: c = FRAC_NONE;
			3'd4: c = FRAC_HALF;
			3'd5: c = FRAC_HALF;
			3'd6: c = FRAC_QUARTER;
			3'd7: c = FRAC_EIGHTH;
			default: c = FRAC_NONE;
		endcase
		return c;
	endfunction

	// Newer chip: index bit per eighth
	function automatic logic newer_frac_index(input logic [2:0] f);
		logic b;
		case (f)
			3'd3, 3'd5, 3'd6, 3'd7: b = 1'b1;
			default: b = 1'b0;
		endcase
		return b;
	endfunction

	// Older chip: fraction code per eighth (seven is rounded up beforehand)
	function automatic logic [1:0] older_frac_code(input logic [2:0] f);
		logic [1:0] c;
		case (f)
			3'd0: c = FRAC_NONE;
			3'd1: c = FRAC_EIGHTH;
			3'd2, 3'd3: c = FRAC_QUARTER;
			3'd4, 3'd5, 3'd6: c = FRAC_HALF;
			default: c = FRAC_NONE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> src/fbde_if.sv
// ----------------------------------------------------------------------------
// fbde_if
// Valid/ready channels: baud request in, encoded divisor out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbde_req_if import fbde_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BAUD_W-1:0] baud_rate;

	modport source (output valid, output baud_rate, input ready);
	modport sink   (input valid, input baud_rate, output ready);
endinterface

interface fbde_rsp_if import fbde_pkg::*;;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] divisor_word;
	logic              divisor_index;
	logic              out_of_range;

	modport source (output valid, output divisor_word, output divisor_index,
		output out_of_range, input ready);
	modport sink   (input valid, input divisor_word, input divisor_index,
		input out_of_range, output ready);
endinterface

`default_nettype wire

>>> src/fbde_div_cell.sv
// ----------------------------------------------------------------------------
// fbde_div_cell
// One restoring-division cell: brings in one dividend bit, resolves one
// quotient bit and hands remainder, quotient and divisor to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fbde_div_cell import fbde_pkg::*; #(
	parameter int QW   = 25,
	parameter bit DBIT = 1'b0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire cell_ctl_t         ctl_in,
	input  wire logic [BAUD_W-1:0] divisor_in,
	input  wire logic [BAUD_W-1:0] rem_in,
	input  wire logic [QW-1:0]     quo_in,
	output cell_ctl_t              ctl_out,
	output logic [BAUD_W-1:0]      divisor_out,
	output logic [BAUD_W-1:0]      rem_out,
	output logic [QW-1:0]          quo_out
);

	logic [BAUD_W:0]   partial;
	logic [BAUD_W+1:0] diff;
	logic              qbit;
	logic [BAUD_W-1:0] rem_next;
	cell_ctl_t         ctl_q;
	logic [BAUD_W-1:0] divisor_q;
	logic [BAUD_W-1:0] rem_q;
	logic [QW-1:0]     quo_q;

	// Trial subtract of the divisor from the shifted remainder
	assign partial  = {rem_in, DBIT};
	assign diff     = {1'b0, partial} - {2'b00, divisor_in};
	assign qbit     = ~diff[BAUD_W+1];
	assign rem_next = qbit ? diff[BAUD_W-1:0] : partial[BAUD_W-1:0];

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (en) begin
			divisor_q <= divisor_in;
			rem_q     <= rem_next;
			quo_q     <= {quo_in[QW-2:0], qbit};
		end
	end

	assign ctl_out     = ctl_q;
	assign divisor_out = divisor_q;
	assign rem_out     = rem_q;
	assign quo_out     = quo_q;

endmodule

`default_nettype wire

>>> src/fbde_out_stage.sv
// ----------------------------------------------------------------------------
// fbde_out_stage
// Encodes the eighths quotient for the selected chip generation and holds
// the result in an output register backed by one skid entry.
// ----------------------------------------------------------------------------
`default_nettype none

module fbde_out_stage import fbde_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire cell_ctl_t          ctl_in,
	input  wire logic [EIGHT_W-1:0] eighths,
	input  wire chip_mode_t         chip_mode,
	output logic                    skid_full,
	fbde_rsp_if.source              rsp
);

	logic [EIGHT_W-1:0] older_e;
	logic [WORD_W-1:0]  older_w;
	logic [WORD_W-1:0]  newer_w;
	logic               newer_i;
	logic [WORD_W-1:0]  enc_word;
	logic               enc_index;
	logic               new_valid;
	logic               out_valid_q;
	logic [WORD_W-1:0]  out_word_q;
	logic               out_index_q;
	logic               out_oor_q;
	logic               skid_valid_q;
	logic [WORD_W-1:0]  skid_word_q;
	logic               skid_index_q;
	logic               skid_oor_q;

	// Older chip: round seven eighths up, three fraction codes
	always_comb begin
		older_e = (eighths[2:0] == 3'd7) ? eighths + EIGHT_W'(1) : eighths;
		older_w = {older_frac_code(older_e[2:0]), older_e[EIGHT_W-1:3]};
		if (older_w == WORD_ONE) begin
			older_w = WORD_ZERO;
		end
	end

	// Newer chip: table code plus index bit
	always_comb begin
		newer_i = newer_frac_index(eighths[2:0]);
		newer_w = {newer_frac_code(eighths[2:0]), eighths[EIGHT_W-1:3]};
		if (newer_w == WORD_ONE && !newer_i) begin
			newer_w = WORD_ZERO;
		end else if (newer_w == WORD_HALF_ONE && !newer_i) begin
			newer_w = WORD_ONE;
		end
	end

	// Mode select and range flag
	always_comb begin
		if (ctl_in.oor) begin
			enc_word  = WORD_ZERO;
			enc_index = 1'b0;
		end else if (chip_mode == CHIP_OLDER) begin
			enc_word  = older_w;
			enc_index = 1'b0;
		end else begin
			enc_word  = newer_w;
			enc_index = newer_i;
		end
	end

	assign new_valid = en & ctl_in.valid;

	// Output register and skid entry, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || rsp.ready) begin
			out_valid_q  <= skid_valid_q | new_valid;
			skid_valid_q <= 1'b0;
		end else if (new_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output register and skid entry, payload
	always_ff @(posedge clk) begin
		if (!out_valid_q || rsp.ready) begin
			if (skid_valid_q) begin
				out_word_q  <= skid_word_q;
				out_index_q <= skid_index_q;
				out_oor_q   <= skid_oor_q;
			end else begin
				out_word_q  <= enc_word;
				out_index_q <= enc_index;
				out_oor_q   <= ctl_in.oor;
			end
		end else if (new_valid) begin
			skid_word_q  <= enc_word;
			skid_index_q <= enc_index;
			skid_oor_q   <= ctl_in.oor;
		end
	end

	assign skid_full         = skid_valid_q;
	assign rsp.valid         = out_valid_q;
	assign rsp.divisor_word  = out_word_q;
	assign rsp.divisor_index = out_index_q;
	assign rsp.out_of_range  = out_oor_q;

endmodule

`default_nettype wire

>>> src/fractional_baud_divisor_encoder.sv
// ----------------------------------------------------------------------------
// fractional_baud_divisor_encoder
// Pipeline: QW divider cells, one per quotient bit, then the output register;
// QW = bits of REF_CLOCK_HZ/2 (25 at 48 MHz).
// Throughput: one request per cycle; the cell chain stalls only while the
// skid entry behind the output register is full.
// Reset: arst_n clears all valid bits and sets chip_mode to the newer chip.
// ----------------------------------------------------------------------------
`default_nettype none

module fractional_baud_divisor_encoder import fbde_pkg::*; #(
	parameter int unsigned REF_CLOCK_HZ = REF_CLOCK_HZ_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	fbde_req_if.sink  req,
	fbde_rsp_if.source rsp
);

	localparam int unsigned DIVIDEND = REF_CLOCK_HZ / 2;
	localparam int          QW       = $clog2(DIVIDEND + 1);
	localparam logic [QW-1:0] DIVIDEND_V = QW'(DIVIDEND);

	chip_mode_t        chip_mode_q;
	logic              en;
	logic              skid_full;
	cell_ctl_t         ctl_c     [QW+1];
	logic [BAUD_W-1:0] divisor_c [QW+1];
	logic [BAUD_W-1:0] rem_c     [QW+1];
	logic [QW-1:0]     quo_c     [QW+1];

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_mode_q <= CHIP_NEWER;
		end else if (cfg_we) begin
			chip_mode_q <= chip_mode_t'(cfg_wdata);
		end
	end

	// Chain advances unless the skid entry is occupied
	assign en        = ~skid_full;
	assign req.ready = en;

	// Head of the chain: range check, empty remainder
	assign ctl_c[0].valid = req.valid;
	assign ctl_c[0].oor   = (req.baud_rate < BAUD_MIN) || (req.baud_rate > BAUD_MAX);
	assign divisor_c[0]   = req.baud_rate;
	assign rem_c[0]       = '0;
	assign quo_c[0]       = '0;

	// One cell per quotient bit, most significant first
	for (genvar k = 0; k < QW; k++) begin : g_cell
		fbde_div_cell #(
			.QW   (QW),
			.DBIT (DIVIDEND_V[QW-1-k])
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (en),
			.ctl_in      (ctl_c[k]),
			.divisor_in  (divisor_c[k]),
			.rem_in      (rem_c[k]),
			.quo_in      (quo_c[k]),
			.ctl_out     (ctl_c[k+1]),
			.divisor_out (divisor_c[k+1]),
			.rem_out     (rem_c[k+1]),
			.quo_out     (quo_c[k+1])
		);
	end

	// Encoding and output buffering
	fbde_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_in    (ctl_c[QW]),
		.eighths   (quo_c[QW][EIGHT_W-1:0]),
		.chip_mode (chip_mode_q),
		.skid_full (skid_full),
		.rsp       (rsp)
	);

	// An out-of-range result carries no divisor
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.out_of_range |-> rsp.divisor_word == WORD_ZERO && !rsp.divisor_index)
		else $error("out-of-range result with nonzero divisor");

	// The skid entry is only occupied behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full |-> rsp.valid)
		else $error("skid entry full while output register empty");

	// The skid entry fills only when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full) |-> $past(rsp.valid && !rsp.ready))
		else $error("skid entry filled without output stall");

endmodule

`default_nettype wire

>>> tb/fractional_baud_divisor_encoder_tb.sv
// ----------------------------------------------------------------------------
// fractional_baud_divisor_encoder_tb
// Sends baud requests through the valid/ready request channel and checks each
// encoded divisor against a local predictor of the eighths encoding, for both
// chip generations. Directed edge cases come first, then random requests under
// several handshake pacing phases, with the chip mode rewritten while idle.
// ----------------------------------------------------------------------------

module fractional_baud_divisor_encoder_tb;
	import fbde_pkg::*;

	localparam int unsigned HALF_REF_HZ = REF_CLOCK_HZ_DEF / 2;
	// one divider cell per quotient bit of the half reference clock
	localparam int LATENCY      = 25;
	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_ITEMS = 1550;

	// newer chip tables, indexed by the eighths fraction (entry 0 at the right)
	localparam logic [15:0] NEWER_CODE_TAB = {FRAC_EIGHTH, FRAC_QUARTER, FRAC_HALF,
		FRAC_HALF, FRAC_NONE, FRAC_QUARTER, FRAC_EIGHTH, FRAC_NONE};
	localparam logic [7:0]  NEWER_IDX_TAB  = 8'b1110_1000;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              index;
		logic              oor;
	} divisor_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	fbde_req_if req_ch ();
	fbde_rsp_if rsp_ch ();

	fractional_baud_divisor_encoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	divisor_t   pending_divisors[$];
	chip_mode_t chip_mode_q;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         n_errors;
	int         n_sent;
	int         n_oor;
	int         n_checked;
	int         n_mode_writes;
	int         n_per_mode[2];
	int         idle_cycles;

	// Clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Expected encoding of one baud request
	function automatic divisor_t predict_divisor(input logic [BAUD_W-1:0] baud,
		input chip_mode_t mode);
		divisor_t    r;
		logic [31:0] eighths;
		logic [2:0]  f;
		r = '0;
		if (baud < BAUD_MIN || baud > BAUD_MAX) begin
			r.oor = 1'b1;
			return r;
		end
		eighths = HALF_REF_HZ / 32'(baud);
		if (mode == CHIP_OLDER) begin
			// seven eighths round up to the next integer
			if (eighths[2:0] == 3'd7)
				eighths = eighths + 32'd1;
			f      = eighths[2:0];
			r.word = {FRAC_NONE, eighths[16:3]};
			if (f == 3'd1)
				r.word[15:14] = FRAC_EIGHTH;
			else if (f >= 3'd4)
				r.word[15:14] = FRAC_HALF;
			else if (f != 3'd0)
				r.word[15:14] = FRAC_QUARTER;
			if (r.word == WORD_ONE)
				r.word = WORD_ZERO;
		end else begin
			f       = eighths[2:0];
			r.word  = {NEWER_CODE_TAB[{f, 1'b0} +: 2], eighths[16:3]};
			r.index = NEWER_IDX_TAB[f];
			// top-rate remaps apply only with the index bit clear
			if (!r.index && r.word == WORD_ONE)
				r.word = WORD_ZERO;
			else if (!r.index && r.word == WORD_HALF_ONE)
				r.word = WORD_ONE;
		end
		return r;
	endfunction

	// Random request rate, biased toward the legal range and its edges
	function automatic logic [BAUD_W-1:0] pick_baud();
		int unsigned hi;
		case ($urandom_range(9))
			0, 1, 2: return BAUD_W'($urandom_range(0, (1 << BAUD_W) - 1));
			3: begin
				if ($urandom_range(1))
					return BAUD_MIN - 24'd4 + BAUD_W'($urandom_range(8));
				return BAUD_MAX - 24'd4 + BAUD_W'($urandom_range(8));
			end
			4: return BAUD_W'($urandom_range(1500000, BAUD_MAX));
			default: begin
				hi = 32'(BAUD_MIN) << $urandom_range(0, 16);
				if (hi > 32'(BAUD_MAX))
					hi = 32'(BAUD_MAX);
				return BAUD_W'($urandom_range(32'(BAUD_MIN), hi));
			end
		endcase
	endfunction

	// Response side pacing
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Result checker
	always @(posedge clk) begin : check_results
		divisor_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_divisors.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result word=%h index=%b oor=%b", $time,
					rsp_ch.divisor_word, rsp_ch.divisor_index, rsp_ch.out_of_range);
			end else begin
				want = pending_divisors.pop_front();
				n_checked++;
				if (rsp_ch.divisor_word !== want.word) begin
					n_errors++;
					$display("%0t: divisor_word expected %h actual %h", $time,
						want.word, rsp_ch.divisor_word);
				end
				if (rsp_ch.divisor_index !== want.index) begin
					n_errors++;
					$display("%0t: divisor_index expected %b actual %b", $time,
						want.index, rsp_ch.divisor_index);
				end
				if (rsp_ch.out_of_range !== want.oor) begin
					n_errors++;
					$display("%0t: out_of_range expected %b actual %b", $time,
						want.oor, rsp_ch.out_of_range);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// One request transfer; valid stays high into the next call unless it idles
	task automatic send_baud(input logic [BAUD_W-1:0] baud);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.baud_rate <= baud;
		do @(posedge clk); while (!req_ch.ready);
		pending_divisors.push_back(predict_divisor(baud, chip_mode_q));
		n_sent++;
		n_per_mode[chip_mode_q]++;
		if (baud < BAUD_MIN || baud > BAUD_MAX)
			n_oor++;
	endtask

	// Drain, then write the chip mode register
	task automatic write_chip_mode(input chip_mode_t mode);
		req_ch.valid <= 1'b0;
		while (pending_divisors.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we      <= 1'b0;
		chip_mode_q  = mode;
		n_mode_writes++;
	endtask

	task automatic set_pacing(input int idle_pct, input int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	// Both ends of the legal range and the all-ones / zero rates
	task automatic test_range_limits();
		write_chip_mode(CHIP_NEWER);
		send_baud('0);
		send_baud(BAUD_MIN - 24'd1);
		send_baud(BAUD_MIN);
		send_baud(BAUD_MAX);
		send_baud(BAUD_MAX + 24'd1);
		send_baud('1);
	endtask

	// Every eighths fraction, including seven eighths rounding up in the older mode
	task automatic test_fraction_codes(input chip_mode_t mode);
		write_chip_mode(mode);
		for (int e = 7; e <= 15; e++)
			send_baud(BAUD_W'(HALF_REF_HZ / e));
	endtask

	// Divisors below one: word 0 with index set, pure half, three quarters
	task automatic test_top_rates();
		write_chip_mode(CHIP_NEWER);
		send_baud(BAUD_W'(HALF_REF_HZ / 3));
		send_baud(BAUD_W'(HALF_REF_HZ / 4));
		send_baud(BAUD_W'(HALF_REF_HZ / 6));
	endtask

	// Random requests across pacing phases, both chip modes in each
	task automatic test_random_traffic(input int n_items);
		int per_chunk;
		per_chunk = n_items / 8;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_pacing(0, 0);
				1: set_pacing(86, 0);
				2: set_pacing(0, 86);
				default: set_pacing(6, 6);
			endcase
			for (int m = 0; m < 2; m++) begin
				write_chip_mode(m ? CHIP_NEWER : CHIP_OLDER);
				repeat (per_chunk) send_baud(pick_baud());
			end
		end
		set_pacing(0, 0);
	endtask

	// Sequence
	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.baud_rate = '0;
		rsp_ch.ready     = 1'b0;
		chip_mode_q      = CHIP_NEWER;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		n_errors         = 0;
		n_sent           = 0;
		n_oor            = 0;
		n_checked        = 0;
		n_mode_writes    = 0;
		n_per_mode       = '{0, 0};
		idle_cycles      = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_range_limits();
		test_fraction_codes(CHIP_OLDER);
		test_fraction_codes(CHIP_NEWER);
		test_top_rates();
		test_random_traffic(RANDOM_ITEMS);

		req_ch.valid <= 1'b0;
		while (pending_divisors.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("Covered %0d requests (%0d out of range), %0d results checked.",
			n_sent, n_oor, n_checked);
		$display("Newer chip %0d, older chip %0d requests; %0d mode writes, 4 pacing phases.",
			n_per_mode[CHIP_NEWER], n_per_mode[CHIP_OLDER], n_mode_writes);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> filelist.f
src/fbde_pkg.sv
src/fbde_if.sv
src/fbde_div_cell.sv
src/fbde_out_stage.sv
src/fractional_baud_divisor_encoder.sv
tb/fractional_baud_divisor_encoder_tb.sv
